### rtl/core/assert_macros.svh
// assertion macros shared by the pcm remix core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: property violated");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### rtl/core/pcrc_pkg.sv
// types, codes and helper functions of the pcm remix and convert core
package pcrc_pkg;

  localparam int MAX_CHANNELS = 6;
  localparam int RAW_W        = 32;
  localparam int SAMPLE_W     = 30;
  localparam int QUEUE_DEPTH  = 4;   // power of two, pointers wrap naturally
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);

  // source formats
  localparam logic [1:0] SRC_U8  = 2'd0;
  localparam logic [1:0] SRC_S16 = 2'd1;
  localparam logic [1:0] SRC_S24 = 2'd2;
  localparam logic [1:0] SRC_S32 = 2'd3;

  // destination formats
  localparam logic [2:0] DST_U8  = 3'd0;
  localparam logic [2:0] DST_S16 = 3'd1;
  localparam logic [2:0] DST_S24 = 3'd2;
  localparam logic [2:0] DST_S32 = 3'd3;
  localparam logic [2:0] DST_F32 = 3'd4;

  // output layouts
  localparam logic [3:0] MODE_MONO    = 4'd0;
  localparam logic [3:0] MODE_STEREO  = 4'd1;
  localparam logic [3:0] MODE_2_1     = 4'd2;
  localparam logic [3:0] MODE_3_0     = 4'd3;
  localparam logic [3:0] MODE_3_1     = 4'd4;
  localparam logic [3:0] MODE_SUR_3_0 = 4'd5;
  localparam logic [3:0] MODE_SUR_3_1 = 4'd6;
  localparam logic [3:0] MODE_SUR_4_0 = 4'd7;
  localparam logic [3:0] MODE_SUR_4_1 = 4'd8;
  localparam logic [3:0] MODE_3F1R_0  = 4'd9;
  localparam logic [3:0] MODE_3F1R_1  = 4'd10;
  localparam logic [3:0] MODE_SUR_5_0 = 4'd11;
  localparam logic [3:0] MODE_SUR_5_1 = 4'd12;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_FMT  = 3'd0;
  localparam logic [2:0] CFG_SRC_CH   = 3'd1;
  localparam logic [2:0] CFG_DST_FMT  = 3'd2;
  localparam logic [2:0] CFG_DST_MODE = 3'd3;

  // output positions
  localparam logic [2:0] POS_LEFT   = 3'd0;
  localparam logic [2:0] POS_CENTRE = 3'd1;
  localparam logic [2:0] POS_RIGHT  = 3'd2;
  localparam logic [2:0] POS_REAR_L = 3'd3;
  localparam logic [2:0] POS_REAR_R = 3'd4;
  localparam logic [2:0] POS_LFE    = 3'd5;

  // one-hot channel selects into the widened frame
  localparam logic [MAX_CHANNELS-1:0] M_NONE = 6'b000000;
  localparam logic [MAX_CHANNELS-1:0] M_L    = 6'b000001;
  localparam logic [MAX_CHANNELS-1:0] M_C    = 6'b000010;
  localparam logic [MAX_CHANNELS-1:0] M_R    = 6'b000100;
  localparam logic [MAX_CHANNELS-1:0] M_RL   = 6'b001000;
  localparam logic [MAX_CHANNELS-1:0] M_RR   = 6'b010000;
  localparam logic [MAX_CHANNELS-1:0] M_LFE  = 6'b100000;

  // slot indexes of the widened frame
  localparam int CH_L   = 0;
  localparam int CH_C   = 1;
  localparam int CH_R   = 2;
  localparam int CH_RL  = 3;
  localparam int CH_RR  = 4;
  localparam int CH_LFE = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAT_MAX = 30'h1FFF_FFFF;
  localparam sample_t SAT_MIN = 30'h2000_0000;

  localparam logic [7:0] FLT_EXP_OFS = 8'd98;  // 127 bias minus the 29-bit scale

  typedef struct packed {
    logic [1:0] src_fmt;
    logic [2:0] src_ch;
    logic [2:0] dst_fmt;
    logic [3:0] dst_mode;
  } cfg_t;

  // one output sample: sat(asr(pa + pb + fold(qa * (1 + qdbl) + qb + qc), half))
  typedef struct packed {
    logic [2:0]              pos;
    logic [MAX_CHANNELS-1:0] pa;
    logic [MAX_CHANNELS-1:0] pb;
    logic [MAX_CHANNELS-1:0] qa;
    logic [MAX_CHANNELS-1:0] qb;
    logic [MAX_CHANNELS-1:0] qc;
    logic                    qdbl;
    logic                    half;
  } slot_t;

  typedef struct packed {
    slot_t [MAX_CHANNELS-1:0] s;
    logic  [2:0]              n;
  } plan_t;

  typedef struct packed {
    sample_t    value;
    logic [2:0] pos;
    logic       last;
    logic       blk;
  } qitem_t;

  function automatic sample_t widen(logic [RAW_W-1:0] raw, logic [1:0] fmt);
    sample_t v;
    case (fmt)
      SRC_U8:  v = {~raw[7], raw[6:0], 22'd0};
      SRC_S16: v = {raw[15:0], 14'd0};
      SRC_S24: v = {raw[23:0], 6'd0};
      SRC_S32: v = raw[31:2];
      default: v = raw[31:2];
    endcase
    return v;
  endfunction

  function automatic logic [2:0] clamp_channels(logic [2:0] src_ch);
    logic [2:0] sc;
    if (src_ch == 3'd0) sc = 3'd1;
    else if (src_ch == 3'd7) sc = 3'd6;
    else sc = src_ch;
    return sc;
  endfunction

  function automatic slot_t mk_slot(logic [2:0] pos, logic [MAX_CHANNELS-1:0] pa,
                                    logic [MAX_CHANNELS-1:0] pb,
                                    logic [MAX_CHANNELS-1:0] qa,
                                    logic [MAX_CHANNELS-1:0] qb,
                                    logic [MAX_CHANNELS-1:0] qc,
                                    logic qdbl, logic half);
    slot_t sl;
    sl.pos  = pos;
    sl.pa   = pa;
    sl.pb   = pb;
    sl.qa   = qa;
    sl.qb   = qb;
    sl.qc   = qc;
    sl.qdbl = qdbl;
    sl.half = half;
    return sl;
  endfunction

  // list of output samples for a channel count and layout
  function automatic plan_t make_plan(logic [2:0] src_ch, logic [3:0] dst_mode);
    plan_t      pl;
    logic [2:0] sc;
    logic [3:0] dm;
    logic       centre;
    logic       lfe;
    logic [1:0] rears;
    slot_t      mid;
    logic [2:0] n;
    sc = clamp_channels(src_ch);
    dm = (dst_mode > MODE_SUR_5_1) ? MODE_SUR_5_1 : dst_mode;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      pl.s[i] = mk_slot(POS_LEFT, M_NONE, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
    end
    n = 3'd0;
    centre = 1'b0;
    lfe = 1'b0;
    rears = 2'd0;
    mid = mk_slot(POS_CENTRE, M_C, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
    if (dm == MODE_MONO) begin
      // absent channels are zero, so the fold vanishes for small sources
      pl.s[0] = mk_slot(POS_LEFT, M_L, M_R, M_C, M_RL, M_RR, 1'b1, 1'b1);
      n = 3'd1;
    end else if (dm <= MODE_2_1) begin
      pl.s[0] = mk_slot(POS_LEFT, M_L, M_NONE, M_C, M_RL, M_NONE, 1'b0, 1'b0);
      pl.s[1] = mk_slot(POS_RIGHT, M_R, M_NONE, M_C, M_RR, M_NONE, 1'b0, 1'b0);
      n = 3'd2;
      if (dm == MODE_2_1) begin
        pl.s[2] = mk_slot(POS_LFE, M_LFE, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
        n = 3'd3;
      end
    end else begin
      centre = (dm == MODE_3_0) || (dm == MODE_3_1) || (dm >= MODE_3F1R_0);
      lfe    = (dm >= MODE_3_1) && !dm[0];
      if (dm <= MODE_3_1) rears = 2'd0;
      else if ((dm == MODE_SUR_3_0) || (dm == MODE_SUR_3_1) ||
               (dm == MODE_3F1R_0) || (dm == MODE_3F1R_1)) rears = 2'd1;
      else rears = 2'd2;
      if ((sc == 3'd2) || (sc == 3'd4)) begin
        mid = mk_slot(POS_CENTRE, M_L, M_R, M_NONE, M_NONE, M_NONE, 1'b0, 1'b1);
      end
      if (rears == 2'd0) begin
        pl.s[0] = mk_slot(POS_LEFT, M_L, M_NONE, M_RL, M_NONE, M_NONE, 1'b0, 1'b0);
        pl.s[1] = mid;
        pl.s[2] = mk_slot(POS_RIGHT, M_R, M_NONE, M_RR, M_NONE, M_NONE, 1'b0, 1'b0);
        n = 3'd3;
      end else if (centre) begin
        pl.s[0] = mk_slot(POS_LEFT, M_L, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
        pl.s[1] = mid;
        pl.s[2] = mk_slot(POS_RIGHT, M_R, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
        n = 3'd3;
      end else begin
        pl.s[0] = mk_slot(POS_LEFT, M_L, M_NONE, M_C, M_NONE, M_NONE, 1'b0, 1'b0);
        pl.s[1] = mk_slot(POS_RIGHT, M_R, M_NONE, M_C, M_NONE, M_NONE, 1'b0, 1'b0);
        n = 3'd2;
      end
      if (rears == 2'd1) begin
        pl.s[n] = mk_slot(POS_REAR_L, M_RL, M_RR, M_NONE, M_NONE, M_NONE, 1'b0, 1'b1);
        n = n + 3'd1;
      end else if (rears == 2'd2) begin
        pl.s[n] = mk_slot(POS_REAR_L, M_RL, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
        n = n + 3'd1;
        pl.s[n] = mk_slot(POS_REAR_R, M_RR, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      if (lfe) begin
        pl.s[n] = mk_slot(POS_LFE, M_LFE, M_NONE, M_NONE, M_NONE, M_NONE, 1'b0, 1'b0);
        n = n + 3'd1;
      end
    end
    pl.n = n;
    return pl;
  endfunction

endpackage

### rtl/core/pcrc_front.sv
// front end: takes frames, widens, mixes one sample per cycle unless q_full
`include "assert_macros.svh"

module pcrc_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pcrc_pkg::cfg_t                        cfg,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // chan0_raw [31:0], chan1_raw, ... chan5_raw [191:160]
  input  logic [pcrc_pkg::MAX_CHANNELS*pcrc_pkg::RAW_W-1:0] s_tdata,
  input  logic                                  s_tlast,
  output logic                                  push,
  output pcrc_pkg::qitem_t                      push_item,
  input  logic                                  q_full
);

  pcrc_pkg::sample_t wide   [pcrc_pkg::MAX_CHANNELS];
  pcrc_pkg::sample_t mapped [pcrc_pkg::MAX_CHANNELS];
  pcrc_pkg::sample_t ch     [pcrc_pkg::MAX_CHANNELS];
  logic              fr_valid;
  logic              fr_blk;
  logic [2:0]        k;
  logic [2:0]        sc;

  pcrc_pkg::plan_t   plan;
  pcrc_pkg::slot_t   slot;
  logic              en;
  logic              issue;
  logic              last_slot;
  logic              accept;

  pcrc_pkg::sample_t pa_v, pb_v, qa_v, qb_v, qc_v;
  logic signed [30:0] p_sum;
  logic signed [32:0] qa_x;
  logic signed [32:0] q_sum;

  logic               r1_valid;
  logic signed [30:0] r1_p;
  logic signed [32:0] r1_q;
  logic               r1_half;
  logic [2:0]         r1_pos;
  logic               r1_last;
  logic               r1_blk;

  logic               r2_valid;
  logic signed [30:0] r2_p;
  logic signed [32:0] r2_f;
  logic               r2_half;
  logic [2:0]         r2_pos;
  logic               r2_last;
  logic               r2_blk;

  logic signed [33:0] sum;
  logic signed [33:0] scaled;
  pcrc_pkg::sample_t  sat_val;

  // input channel layout onto L C R RL RR LFE
  always_comb begin
    sc = pcrc_pkg::clamp_channels(cfg.src_ch);
    for (int i = 0; i < pcrc_pkg::MAX_CHANNELS; i++) begin
      wide[i]   = pcrc_pkg::widen(s_tdata[i*pcrc_pkg::RAW_W +: pcrc_pkg::RAW_W], cfg.src_fmt);
      mapped[i] = '0;
    end
    case (sc)
      3'd1: begin
        mapped[pcrc_pkg::CH_L] = wide[0];
        mapped[pcrc_pkg::CH_R] = wide[0];
      end
      3'd2: begin
        mapped[pcrc_pkg::CH_L] = wide[0];
        mapped[pcrc_pkg::CH_R] = wide[1];
      end
      3'd3: begin
        mapped[pcrc_pkg::CH_L] = wide[0];
        mapped[pcrc_pkg::CH_C] = wide[1];
        mapped[pcrc_pkg::CH_R] = wide[2];
      end
      3'd4: begin
        mapped[pcrc_pkg::CH_L]  = wide[0];
        mapped[pcrc_pkg::CH_R]  = wide[1];
        mapped[pcrc_pkg::CH_RL] = wide[2];
        mapped[pcrc_pkg::CH_RR] = wide[3];
      end
      3'd5: begin
        for (int i = 0; i < 5; i++) mapped[i] = wide[i];
      end
      default: begin
        for (int i = 0; i < pcrc_pkg::MAX_CHANNELS; i++) mapped[i] = wide[i];
      end
    endcase
  end

  always_comb begin
    plan      = pcrc_pkg::make_plan(cfg.src_ch, cfg.dst_mode);
    slot      = plan.s[k];
    en        = !r2_valid || !q_full;
    issue     = fr_valid && en;
    last_slot = (k == (plan.n - 3'd1));
    s_tready  = !fr_valid || (issue && last_slot);
    accept    = s_tvalid && s_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
      k        <= '0;
    end else if (accept) begin
      fr_valid <= 1'b1;
      k        <= '0;
    end else if (issue) begin
      if (last_slot) fr_valid <= 1'b0;
      else k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch     <= mapped;
      fr_blk <= s_tlast;
    end
  end

  // operand pick by and-or over the one-hot selects
  always_comb begin
    pa_v = '0;
    pb_v = '0;
    qa_v = '0;
    qb_v = '0;
    qc_v = '0;
    for (int i = 0; i < pcrc_pkg::MAX_CHANNELS; i++) begin
      pa_v = pa_v | (slot.pa[i] ? ch[i] : '0);
      pb_v = pb_v | (slot.pb[i] ? ch[i] : '0);
      qa_v = qa_v | (slot.qa[i] ? ch[i] : '0);
      qb_v = qb_v | (slot.qb[i] ? ch[i] : '0);
      qc_v = qc_v | (slot.qc[i] ? ch[i] : '0);
    end
    p_sum = 31'(pa_v) + 31'(pb_v);
    qa_x  = slot.qdbl ? (33'(qa_v) <<< 1) : 33'(qa_v);
    q_sum = qa_x + 33'(qb_v) + 33'(qc_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= issue;
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_p    <= p_sum;
      r1_q    <= q_sum;
      r1_half <= slot.half;
      r1_pos  <= slot.pos;
      r1_last <= last_slot;
      r1_blk  <= last_slot && fr_blk;
      // fold at 0.75 gain
      r2_f    <= r1_q - (r1_q >>> 2);
      r2_p    <= r1_p;
      r2_half <= r1_half;
      r2_pos  <= r1_pos;
      r2_last <= r1_last;
      r2_blk  <= r1_blk;
    end
  end

  always_comb begin
    sum    = 34'(r2_p) + 34'(r2_f);
    scaled = r2_half ? (sum >>> 1) : sum;
    if ((scaled[33:29] == 5'b00000) || (scaled[33:29] == 5'b11111)) begin
      sat_val = scaled[29:0];
    end else begin
      sat_val = scaled[33] ? pcrc_pkg::SAT_MIN : pcrc_pkg::SAT_MAX;
    end
    push            = r2_valid && !q_full;
    push_item.value = sat_val;
    push_item.pos   = r2_pos;
    push_item.last  = r2_last;
    push_item.blk   = r2_blk;
  end

  `ASSERT_CLK(a_k_in_plan, clk, rst, fr_valid |-> (k < plan.n))
  `ASSERT_CLK(a_accept_loads, clk, rst, (s_tvalid && s_tready) |=> (fr_valid && (k == 3'd0)))
  `ASSERT_CLK(a_stall_holds, clk, rst, (r2_valid && q_full) |=> r2_valid)

endmodule

### rtl/core/pcrc_queue.sv
// short sample queue between the mixing front end and the encoder
`include "assert_macros.svh"

module pcrc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pcrc_pkg::qitem_t push_item,
  output logic             full,
  input  logic             pop,
  output pcrc_pkg::qitem_t pop_item,
  output logic             empty
);

  pcrc_pkg::qitem_t              entries [pcrc_pkg::QUEUE_DEPTH];
  logic [pcrc_pkg::PTR_W-1:0]    wr_ptr;
  logic [pcrc_pkg::PTR_W-1:0]    rd_ptr;
  logic [pcrc_pkg::PTR_W:0]      count;

  always_comb begin
    full     = (count == (pcrc_pkg::PTR_W+1)'(pcrc_pkg::QUEUE_DEPTH));
    empty    = (count == '0);
    pop_item = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty)
  `ASSERT_CLK(a_count_up, clk, rst, (push && !pop) |=> (count == ($past(count) + 1'b1)))

endmodule

### rtl/core/pcrc_back.sv
// back end: encodes samples to the output format, float path pipelined
module pcrc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       dst_fmt,
  input  logic             empty,
  output logic             pop,
  input  pcrc_pkg::qitem_t pop_item,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // out_sample [31:0]
  output logic [3:0]       m_tuser,   // position [2:0], block_end [3]
  output logic             m_tlast
);

  localparam int LZ_STEPS = 5;

  logic              en;
  pcrc_pkg::sample_t v;
  logic [29:0]       mag;
  logic [31:0]       fixed_code;

  logic        b1_valid, b2_valid, b3_valid;
  logic [29:0] b1_mag, b2_mag, b3_nm;
  logic        b1_sign, b2_sign, b3_sign;
  logic        b1_zero, b2_zero, b3_zero;
  logic [31:0] b1_fixed, b2_fixed, b3_fixed;
  logic [2:0]  b1_pos, b2_pos, b3_pos;
  logic        b1_last, b2_last, b3_last;
  logic        b1_blk, b2_blk, b3_blk;
  logic [4:0]  b2_p, b3_p;

  logic [31:0] lz_x;
  logic [4:0]  lz_p;
  logic [4:0]  lz_sh;

  logic        rnd_up;
  logic [24:0] mant;
  logic [7:0]  fexp;
  logic [22:0] frac;
  logic [31:0] float_code;

  always_comb begin
    en  = !m_tvalid || m_tready;
    pop = en && !empty;
    v   = pop_item.value;
    mag = v[29] ? (~v + 30'd1) : v;
    case (dst_fmt)
      pcrc_pkg::DST_U8:  fixed_code = {24'd0, ~v[29], v[28:22]};
      pcrc_pkg::DST_S16: fixed_code = {16'd0, v[29:14]};
      pcrc_pkg::DST_S24: fixed_code = {8'd0, v[29:6]};
      pcrc_pkg::DST_S32: fixed_code = {v, 2'b00};
      default:           fixed_code = '0;
    endcase
  end

  // highest set bit by halving search
  always_comb begin
    lz_x = {2'b00, b1_mag};
    lz_p = '0;
    for (int i = 0; i < LZ_STEPS; i++) begin
      lz_sh = 5'd16 >> i;
      if ((lz_x >> lz_sh) != '0) begin
        lz_p = lz_p + lz_sh;
        lz_x = lz_x >> lz_sh;
      end
    end
  end

  // round to nearest even on the 24-bit significand
  always_comb begin
    rnd_up = b3_nm[5] && ((|b3_nm[4:0]) || b3_nm[6]);
    mant   = {1'b0, b3_nm[29:6]} + 25'(rnd_up);
    fexp   = 8'(b3_p) + pcrc_pkg::FLT_EXP_OFS + 8'(mant[24]);
    frac   = mant[24] ? 23'd0 : mant[22:0];
    float_code = b3_zero ? 32'd0 : {b3_sign, fexp, frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      b1_valid <= pop;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      m_tvalid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_mag   <= mag;
      b1_sign  <= v[29];
      b1_zero  <= (v == '0);
      b1_fixed <= fixed_code;
      b1_pos   <= pop_item.pos;
      b1_last  <= pop_item.last;
      b1_blk   <= pop_item.blk;

      b2_mag   <= b1_mag;
      b2_p     <= lz_p;
      b2_sign  <= b1_sign;
      b2_zero  <= b1_zero;
      b2_fixed <= b1_fixed;
      b2_pos   <= b1_pos;
      b2_last  <= b1_last;
      b2_blk   <= b1_blk;

      b3_nm    <= b2_mag << (5'd29 - b2_p);
      b3_p     <= b2_p;
      b3_sign  <= b2_sign;
      b3_zero  <= b2_zero;
      b3_fixed <= b2_fixed;
      b3_pos   <= b2_pos;
      b3_last  <= b2_last;
      b3_blk   <= b2_blk;

      m_tdata  <= (dst_fmt == pcrc_pkg::DST_F32) ? float_code : b3_fixed;
      m_tuser  <= {b3_blk, b3_pos};
      m_tlast  <= b3_last;
    end
  end

endmodule

### rtl/core/pcm_channel_remix_convert_core.sv
// top level of the pcm sample format conversion and channel remix core
//
// s_* carries one input frame per beat: six raw channel words and the block
// end marker on s_tlast. m_* carries one output sample per beat in the order
// left, centre, right, rears, lfe; m_tlast marks the frame's last sample and
// m_tuser holds its position and the block end flag.
// cfg_* writes the four setup registers (format, channel count, output
// format, output layout); cfg_ready is always high. Write them only while
// the core is idle.
// A frame giving n output samples (1 to 6, set by the layout) occupies the
// sample issue port until its last sample issues, when the next frame can
// be taken; samples leave at one per cycle while m_tready is high. The
// first sample of a frame passes three mixing stages, the queue, and three
// encoder stages ahead of the output register.
// Reset empties the pipeline and queue and loads s16 stereo in and out.
// When m_tready is low the encoder holds, the queue fills and the front end
// then stops taking frames; nothing is dropped.
module pcm_channel_remix_convert_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // chan0_raw [31:0], chan1_raw [63:32], chan2_raw [95:64],
  // chan3_raw [127:96], chan4_raw [159:128], chan5_raw [191:160]
  input  logic [191:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // out_sample [31:0]
  output logic [3:0]   m_tuser,   // position [2:0], block_end [3]
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  pcrc_pkg::cfg_t   cfg;
  logic             push;
  pcrc_pkg::qitem_t push_item;
  logic             q_full;
  logic             pop;
  pcrc_pkg::qitem_t pop_item;
  logic             q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_fmt  <= pcrc_pkg::SRC_S16;
      cfg.src_ch   <= 3'd2;
      cfg.dst_fmt  <= pcrc_pkg::DST_S16;
      cfg.dst_mode <= pcrc_pkg::MODE_STEREO;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcrc_pkg::CFG_SRC_FMT:  cfg.src_fmt  <= cfg_data[1:0];
        pcrc_pkg::CFG_SRC_CH:   cfg.src_ch   <= cfg_data[2:0];
        pcrc_pkg::CFG_DST_FMT:  cfg.dst_fmt  <= cfg_data[2:0];
        pcrc_pkg::CFG_DST_MODE: cfg.dst_mode <= cfg_data;
        default: ;
      endcase
    end
  end

  pcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  pcrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  pcrc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dst_fmt  (cfg.dst_fmt),
    .empty    (q_empty),
    .pop      (pop),
    .pop_item (pop_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
